// File: rtl/core/rsm_pkg.sv
// shared types and constants of the rpn stack machine
`timescale 1ns / 1ps
package rsm_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned VarCountDef   = 256;
  localparam int unsigned WordW         = 32;

  typedef enum logic [4:0] {
    OP_PUSH   = 5'd0,
    OP_LOAD   = 5'd1,
    OP_NOT    = 5'd2,
    OP_OR     = 5'd3,
    OP_AND    = 5'd4,
    OP_ADD    = 5'd5,
    OP_SUB    = 5'd6,
    OP_MUL    = 5'd7,
    OP_DIV    = 5'd8,
    OP_EQ     = 5'd9,
    OP_LT     = 5'd10,
    OP_GT     = 5'd11,
    OP_LE     = 5'd12,
    OP_GE     = 5'd13,
    OP_NE     = 5'd14,
    OP_ASSIGN = 5'd15,
    OP_GO     = 5'd16,
    OP_FGO    = 5'd17,
    OP_WRITE  = 5'd18,
    OP_READ   = 5'd19
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDEF   = 3'd1,
    ST_DIVZERO = 3'd2,
    ST_UNDER   = 3'd3,
    ST_OVER    = 3'd4,
    ST_BADOP   = 3'd5,
    ST_HALTED  = 3'd6
  } status_t;

  // stack cell movement
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP1,
    CMD_POP2,
    CMD_BIN,
    CMD_SET
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

endpackage

// File: rtl/core/rpn_stack_machine_execute.sv
// top level of the rpn stack machine: sequencer, variable store, stack cell row
// each instruction passes the exec state, then the mul or div state for those ops, then fin,
// where it waits until the output register is free; one instruction in flight, so a new
// input transfer is taken only after the last result is committed. the divide loop (one bit
// per cycle) makes div the slowest instruction. reset: synchronous active low; after reset
// the variable store is swept clear, and no input is taken while the sweep runs.
`timescale 1ns / 1ps
module rpn_stack_machine_execute #(
  parameter int unsigned STACK_DEPTH = rsm_pkg::StackDepthDef,
  parameter int unsigned VAR_COUNT   = rsm_pkg::VarCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // mode[4:0], immediate[36:5], read_value[68:37], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // jump_taken[0], jump_target[32:1], write_valid[33],
                                  // write_value[65:34], status[68:66], zeros
);

  localparam int unsigned W   = rsm_pkg::WordW;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VW  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  // sequencer state
  rsm_pkg::state_t state_r, state_nxt;
  logic [VW-1:0]   clr_cnt_r, clr_cnt_nxt;

  // latched instruction
  logic [4:0]   op_r;
  logic [W-1:0] imm_r, rv_r;

  logic [SPW-1:0] sp_r, sp_nxt;
  logic           halted_r, halted_nxt;

  // variable store: assigned mark in the top bit
  logic [W:0]    var_mem [VAR_COUNT];
  logic [W:0]    var_rd_r;
  logic          mem_we;
  logic [VW-1:0] mem_waddr;
  logic [W:0]    mem_wdata;

  // stack cell row, cell 0 is the top of stack
  logic [W-1:0]       cell_q [STACK_DEPTH];
  rsm_pkg::cell_cmd_t cmd, cmd_commit;
  logic [W-1:0]       top_val;

  logic [W-1:0] a, b;
  logic [W-1:0] mul_r;
  logic         div_start, div_done;
  logic [W-1:0] div_q;

  // output register
  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic        out_free, commit;

  // decode
  logic [1:0]        need;
  rsm_pkg::status_t  status;
  logic              jt;
  logic [W-1:0]      jtarget;
  logic              wv;
  logic [W-1:0]      r;
  logic [SPW-1:0]    sp_ok_nxt;
  logic              var_we_ok;
  logic [VW-1:0]     var_waddr_ok;
  logic [W:0]        var_wdata_ok;

  function automatic logic var_ok(input logic [W-1:0] idx);
    var_ok = (idx < W'(VAR_COUNT));
  endfunction

  assign b = cell_q[0];
  assign a = (STACK_DEPTH > 1) ? cell_q[1] : '0;

  assign out_free = !out_valid_r || out_tready;
  assign commit   = (state_r == rsm_pkg::S_FIN) && out_free;

  // instruction decode and error checks, from the latched item and the stack
  always_comb begin
    need         = 2'd2;
    status       = rsm_pkg::ST_OK;
    jt           = 1'b0;
    jtarget      = '0;
    wv           = 1'b0;
    r            = '0;
    cmd          = rsm_pkg::CMD_HOLD;
    sp_ok_nxt    = sp_r;
    var_we_ok    = 1'b0;
    var_waddr_ok = '0;
    var_wdata_ok = '0;
    case (op_r)
      rsm_pkg::OP_PUSH, rsm_pkg::OP_LOAD: need = 2'd0;
      rsm_pkg::OP_NOT, rsm_pkg::OP_GO, rsm_pkg::OP_WRITE, rsm_pkg::OP_READ: need = 2'd1;
      default: need = 2'd2;
    endcase
    if (halted_r) begin
      status = rsm_pkg::ST_HALTED;
    end else if (op_r > 5'(rsm_pkg::OP_READ)) begin
      status = rsm_pkg::ST_BADOP;
    end else if (sp_r < SPW'(need)) begin
      status = rsm_pkg::ST_UNDER;
    end else begin
      case (op_r)
        rsm_pkg::OP_PUSH, rsm_pkg::OP_LOAD: begin
          r = (op_r == 5'(rsm_pkg::OP_LOAD)) ? var_rd_r[W-1:0] : imm_r;
          if (op_r == 5'(rsm_pkg::OP_LOAD) && (!var_ok(imm_r) || !var_rd_r[W]))
            status = rsm_pkg::ST_UNDEF;
          else if (sp_r == SPW'(STACK_DEPTH))
            status = rsm_pkg::ST_OVER;
          cmd       = rsm_pkg::CMD_PUSH;
          sp_ok_nxt = sp_r + 1'b1;
        end
        rsm_pkg::OP_NOT: begin
          r   = W'(b == '0);
          cmd = rsm_pkg::CMD_SET;
        end
        rsm_pkg::OP_ASSIGN: begin
          if (!var_ok(a)) status = rsm_pkg::ST_UNDEF;
          var_we_ok    = 1'b1;
          var_waddr_ok = a[VW-1:0];
          var_wdata_ok = {1'b1, b};
          cmd          = rsm_pkg::CMD_POP2;
          sp_ok_nxt    = sp_r - SPW'(2);
        end
        rsm_pkg::OP_GO: begin
          jt        = 1'b1;
          jtarget   = b;
          cmd       = rsm_pkg::CMD_POP1;
          sp_ok_nxt = sp_r - 1'b1;
        end
        rsm_pkg::OP_FGO: begin
          jt        = (a == '0);
          jtarget   = (a == '0) ? b : '0;
          cmd       = rsm_pkg::CMD_POP2;
          sp_ok_nxt = sp_r - SPW'(2);
        end
        rsm_pkg::OP_WRITE: begin
          wv        = 1'b1;
          cmd       = rsm_pkg::CMD_POP1;
          sp_ok_nxt = sp_r - 1'b1;
        end
        rsm_pkg::OP_READ: begin
          if (!var_ok(b)) status = rsm_pkg::ST_UNDEF;
          var_we_ok    = 1'b1;
          var_waddr_ok = b[VW-1:0];
          var_wdata_ok = {1'b1, rv_r};
          cmd          = rsm_pkg::CMD_POP1;
          sp_ok_nxt    = sp_r - 1'b1;
        end
        default: begin
          // binary operators, result replaces the two top words
          case (op_r)
            rsm_pkg::OP_OR:  r = W'((a != '0) || (b != '0));
            rsm_pkg::OP_AND: r = W'((a != '0) && (b != '0));
            rsm_pkg::OP_ADD: r = a + b;
            rsm_pkg::OP_SUB: r = a - b;
            rsm_pkg::OP_MUL: r = mul_r;
            rsm_pkg::OP_DIV: begin
              r = div_q;
              if (b == '0) status = rsm_pkg::ST_DIVZERO;
            end
            rsm_pkg::OP_EQ:  r = W'(a == b);
            rsm_pkg::OP_LT:  r = W'($signed(a) < $signed(b));
            rsm_pkg::OP_GT:  r = W'($signed(a) > $signed(b));
            rsm_pkg::OP_LE:  r = W'($signed(a) <= $signed(b));
            rsm_pkg::OP_GE:  r = W'($signed(a) >= $signed(b));
            default:         r = W'(a != b);
          endcase
          cmd       = rsm_pkg::CMD_BIN;
          sp_ok_nxt = sp_r - 1'b1;
        end
      endcase
    end
  end

  assign top_val    = r;
  assign cmd_commit = (commit && status == rsm_pkg::ST_OK) ? cmd : rsm_pkg::CMD_HOLD;

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      rsm_pkg::S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == VW'(VAR_COUNT - 1)) state_nxt = rsm_pkg::S_IDLE;
      end
      rsm_pkg::S_IDLE: if (in_tvalid) state_nxt = rsm_pkg::S_EXEC;
      rsm_pkg::S_EXEC: begin
        if (status != rsm_pkg::ST_OK) state_nxt = rsm_pkg::S_FIN;
        else if (op_r == 5'(rsm_pkg::OP_MUL)) state_nxt = rsm_pkg::S_MUL;
        else if (op_r == 5'(rsm_pkg::OP_DIV)) state_nxt = rsm_pkg::S_DIV;
        else state_nxt = rsm_pkg::S_FIN;
      end
      rsm_pkg::S_MUL: state_nxt = rsm_pkg::S_FIN;
      rsm_pkg::S_DIV: if (div_done) state_nxt = rsm_pkg::S_FIN;
      rsm_pkg::S_FIN: if (out_free) state_nxt = rsm_pkg::S_IDLE;
      default: state_nxt = rsm_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready  = (state_r == rsm_pkg::S_IDLE);
    div_start  = (state_r == rsm_pkg::S_EXEC) && (status == rsm_pkg::ST_OK) &&
                 (op_r == 5'(rsm_pkg::OP_DIV));
    mem_we     = 1'b0;
    mem_waddr  = var_waddr_ok;
    mem_wdata  = var_wdata_ok;
    sp_nxt     = sp_r;
    halted_nxt = halted_r;
    case (state_r)
      rsm_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      rsm_pkg::S_FIN: begin
        if (out_free) begin
          if (status == rsm_pkg::ST_OK) begin
            mem_we = var_we_ok;
            sp_nxt = sp_ok_nxt;
          end else begin
            halted_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsm_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      sp_r        <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      sp_r      <= sp_nxt;
      halted_r  <= halted_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // item latch, product register, result register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tdata[4:0];
      imm_r <= in_tdata[36:5];
      rv_r  <= in_tdata[68:37];
    end
    if (state_r == rsm_pkg::S_EXEC) mul_r <= a * b;
    if (commit) begin
      out_data_r <= {3'b000, status, (wv && status == rsm_pkg::ST_OK) ? b : W'(0),
                     wv && (status == rsm_pkg::ST_OK),
                     (status == rsm_pkg::ST_OK) ? jtarget : W'(0),
                     jt && (status == rsm_pkg::ST_OK)};
    end
  end

  // variable store, read at input transfer with the immediate as address
  always_ff @(posedge clk) begin
    if (mem_we) var_mem[mem_waddr] <= mem_wdata;
    if (in_tvalid && in_tready) var_rd_r <= var_mem[in_tdata[VW+4:5]];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  rsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .quotient (div_q)
  );

  // row of stack cells, each shifts toward or away from the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [W-1:0] up_w, dn1_w, dn2_w;
    if (i == 0) begin : g_up_top
      assign up_w = top_val;
    end else begin : g_up_mid
      assign up_w = cell_q[i-1];
    end
    if (i + 1 < STACK_DEPTH) begin : g_dn1
      assign dn1_w = cell_q[i+1];
    end else begin : g_dn1_end
      assign dn1_w = '0;
    end
    if (i + 2 < STACK_DEPTH) begin : g_dn2
      assign dn2_w = cell_q[i+2];
    end else begin : g_dn2_end
      assign dn2_w = '0;
    end
    rsm_cell #(.IS_TOP(i == 0)) u_cell (
      .clk    (clk),
      .cmd    (cmd_commit),
      .up_in  (up_w),
      .dn1_in (dn1_w),
      .dn2_in (dn2_w),
      .q      (cell_q[i])
    );
  end

endmodule

// File: rtl/core/rsm_cell.sv
// one operand stack cell, shifts with its neighbours
`timescale 1ns / 1ps
module rsm_cell #(
  parameter bit IS_TOP = 1'b0
) (
  input  logic                     clk,
  input  rsm_pkg::cell_cmd_t       cmd,
  input  logic [rsm_pkg::WordW-1:0] up_in,
  input  logic [rsm_pkg::WordW-1:0] dn1_in,
  input  logic [rsm_pkg::WordW-1:0] dn2_in,
  output logic [rsm_pkg::WordW-1:0] q
);

  logic [rsm_pkg::WordW-1:0] q_r, q_nxt;

  always_comb begin
    case (cmd)
      rsm_pkg::CMD_PUSH: q_nxt = up_in;
      rsm_pkg::CMD_POP1: q_nxt = dn1_in;
      rsm_pkg::CMD_POP2: q_nxt = dn2_in;
      rsm_pkg::CMD_BIN:  q_nxt = IS_TOP ? up_in : dn1_in;
      rsm_pkg::CMD_SET:  q_nxt = IS_TOP ? up_in : q_r;
      default:           q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// File: rtl/core/rsm_div.sv
// iterative signed truncating divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rsm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rsm_pkg::WordW-1:0] dividend,
  input  logic [rsm_pkg::WordW-1:0] divisor,
  output logic                      done,
  output logic [rsm_pkg::WordW-1:0] quotient
);

  localparam int unsigned W  = rsm_pkg::WordW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]    shifted, trial;

  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    trial    = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend[W-1] ? (~dividend + 1'b1) : dividend;
      dvs_nxt  = divisor[W-1] ? (~divisor + 1'b1) : divisor;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule
